FILE: hdl/acs_pkg.sv
// Package: shared types, opcodes and constants for the accumulator step block.
package acs_pkg;
  localparam int MemDepth  = 128;
  localparam int DataWidth = 32;
  localparam int AddrWidth = $clog2(MemDepth);

  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [DataWidth-1:0] data_t;

  typedef enum logic [1:0] {
    OPN_WRITE = 2'd0, OPN_RESTART = 2'd1, OPN_EXEC = 2'd2, OPN_NONE = 2'd3
  } operation_t;

  typedef enum logic [3:0] {
    OP_LA = 4'd0, OP_SA = 4'd1, OP_ADD = 4'd2, OP_MUL = 4'd3, OP_DIV = 4'd4,
    OP_SUB = 4'd5, OP_JMP = 4'd6, OP_JEQ = 4'd7, OP_JGT = 4'd8, OP_JLT = 4'd9,
    OP_PW = 4'd10, OP_RW = 4'd11, OP_HLT = 4'd12, OP_NOP13 = 4'd13,
    OP_NOP14 = 4'd14, OP_NOP15 = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0, FAULT_ADDR = 2'd1, FAULT_DIV0 = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_OPER, ST_EXEC, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  word_address;
    logic [3:0]  word_opcode;
    logic [31:0] word_operand;
    logic [31:0] keyboard_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  pc_after;
    logic [31:0] acc_after;
    logic [3:0]  executed_opcode;
    logic        print_valid;
    logic [6:0]  print_address;
    logic [31:0] print_value;
    logic        input_taken;
    logic        halted;
    logic [1:0]  fault_code;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic fetch;
    logic oper;
    logic exec;
    logic div_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_exec;
    logic need_div;
    logic div_last;
  } status_t;
endpackage

FILE: hdl/acs_if.sv
// Interfaces: valid/ready request channels for input and result items.
interface acs_in_if;
  import acs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acs_out_if;
  import acs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/acs_ctrl.sv
// Controller: sequences the fetch, operand read, execute and division steps.
module acs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  acs_pkg::status_t  status,
  output acs_pkg::cmd_t     cmd
);
  import acs_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = status.is_exec ? ST_FETCH : ST_EXEC;
      ST_FETCH: state_next = ST_OPER;
      ST_OPER:  state_next = ST_EXEC;
      ST_EXEC:  state_next = status.need_div ? ST_DIV : ST_DONE;
      ST_DIV:   if (status.div_last) state_next = ST_DONE;
      ST_DONE:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_OPER:  cmd.oper = 1'b1;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_DONE:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

FILE: hdl/acs_dpath.sv
// Datapath: memory, pc, accumulator, ALU and a restoring divider.
module acs_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_data,
  input  acs_pkg::in_item_t   in_data,
  input  acs_pkg::cmd_t       cmd,
  output acs_pkg::status_t    status,
  output acs_pkg::out_item_t  out_data
);
  import acs_pkg::*;

  logic [3:0] mem_op [MemDepth];
  data_t      mem_val [MemDepth];

  logic [6:0] start_pc;
  addr_t      pc;
  addr_t      pc_next;
  data_t      acc;
  data_t      acc_next;
  in_item_t   req;
  logic [3:0] op;
  data_t      opnd;
  data_t      m;
  logic [3:0] op_rd;
  data_t      opnd_rd;
  data_t      m_rd;
  out_item_t  res;
  out_item_t  res_next;

  // divider
  logic [DataWidth-1:0] dq, dd;
  logic [DataWidth:0]   drem;
  logic [5:0]           dcnt;
  logic                 dneg;

  addr_t  np;
  logic   addr_ok;
  addr_t  oaddr;
  logic   jump;
  logic [DataWidth:0] trial;
  data_t  qbits;
  data_t  quo;

  assign np = (pc == addr_t'(MemDepth - 1)) ? '0 : pc + addr_t'(1);
  assign addr_ok = ~opnd[DataWidth-1] && (opnd < data_t'(MemDepth));
  assign oaddr = opnd[AddrWidth-1:0];
  assign trial = {drem[DataWidth-1:0], dq[DataWidth-1]} - {1'b0, dd};
  assign qbits = {dq[DataWidth-2:0], ~trial[DataWidth]};
  assign quo = dneg ? data_t'(-qbits) : qbits;

  always_comb begin
    case (opcode_t'(op))
      OP_JMP:  jump = 1'b1;
      OP_JEQ:  jump = (acc == '0);
      OP_JGT:  jump = (acc != '0) && !acc[DataWidth-1];
      OP_JLT:  jump = acc[DataWidth-1];
      default: jump = 1'b0;
    endcase
  end

  assign status.is_exec  = (in_data.operation == OPN_EXEC);
  assign status.need_div = (req.operation == OPN_EXEC) && (op == OP_DIV) && addr_ok
                           && (m != '0);
  assign status.div_last = (dcnt == 6'd1);
  assign out_data = res;

  // operand word is read from the registered operand field opnd_rd into m_rd, then loaded into m
  always_ff @(posedge clk) begin
    op_rd   <= mem_op[pc];
    opnd_rd <= mem_val[pc];
    m_rd    <= mem_val[opnd_rd[AddrWidth-1:0]];
    if (cmd.exec && req.operation == OPN_WRITE) begin
      mem_op[req.word_address]  <= req.word_opcode;
      mem_val[req.word_address] <= req.word_operand;
    end else if (cmd.exec && req.operation == OPN_EXEC && addr_ok) begin
      if (op == OP_SA) mem_val[oaddr] <= acc;
      else if (op == OP_RW) mem_val[oaddr] <= req.keyboard_value;
    end
  end

  always_comb begin
    pc_next  = pc;
    acc_next = acc;
    res_next = res;
    if (cmd.div_step && dcnt == 6'd1) begin
      acc_next = quo;
      res_next.acc_after = quo;
    end
    if (cmd.exec) begin
      res_next = '0;
      case (operation_t'(req.operation))
        OPN_RESTART: begin
          pc_next  = start_pc[AddrWidth-1:0];
          acc_next = '0;
        end
        OPN_EXEC: begin
          res_next.executed_opcode = op;
          pc_next = np;
          case (opcode_t'(op)) inside
            [OP_LA:OP_SUB], OP_PW, OP_RW: begin
              if (!addr_ok) res_next.fault_code = FAULT_ADDR;
              else begin
                case (opcode_t'(op))
                  OP_LA:  acc_next = m;
                  OP_ADD: acc_next = acc + m;
                  OP_SUB: acc_next = acc - m;
                  OP_MUL: acc_next = data_t'(acc * m);
                  OP_DIV: begin
                    if (m == '0) res_next.fault_code = FAULT_DIV0;
                  end
                  OP_PW: begin
                    res_next.print_valid = 1'b1;
                    res_next.print_address = oaddr;
                    res_next.print_value = m;
                  end
                  OP_RW: res_next.input_taken = 1'b1;
                  default: ;
                endcase
              end
            end
            [OP_JMP:OP_JLT]: begin
              if (jump && addr_ok) pc_next = oaddr;
              else if (jump) res_next.fault_code = FAULT_ADDR;
            end
            OP_HLT: begin
              pc_next = pc;
              res_next.halted = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      res_next.pc_after  = pc_next;
      res_next.acc_after = acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= '0;
      pc  <= '0;
      acc <= '0;
    end else begin
      if (cfg_we) start_pc <= cfg_data;
      pc  <= pc_next;
      acc <= acc_next;
      res <= res_next;
      if (cmd.capture) req <= in_data;
      if (cmd.fetch) begin
        op   <= op_rd;
        opnd <= opnd_rd;
      end
      if (cmd.oper) m <= m_rd;
      if (cmd.exec && status.need_div) begin
        dq   <= acc[DataWidth-1] ? data_t'(-acc) : acc;
        dd   <= m[DataWidth-1] ? data_t'(-m) : m;
        drem <= '0;
        dcnt <= 6'(DataWidth);
        dneg <= acc[DataWidth-1] ^ m[DataWidth-1];
      end else if (cmd.div_step) begin
        drem <= trial[DataWidth] ? {drem[DataWidth-1:0], dq[DataWidth-1]} : trial;
        dq   <= qbits;
        dcnt <= dcnt - 6'd1;
      end
    end
  end
endmodule

FILE: hdl/accumulator_cpu_step.sv
// Top level: accumulator machine step block.
// One request executes one step: a write-word, restart or idle request goes
// through execute to its result; an instruction first passes fetch and
// operand read through the registered memory port, and a divide adds the
// steps of the bit-serial restoring divider. A new request is taken once the
// previous result has been accepted.
module accumulator_cpu_step (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  acs_in_if.sink     in_ch,
  acs_out_if.source  out_ch
);
  import acs_pkg::*;
  cmd_t    cmd;
  status_t status;

  acs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(status), .cmd(cmd)
  );

  acs_dpath u_dpath (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_data(in_ch.data), .cmd(cmd), .status(status), .out_data(out_ch.data)
  );
endmodule
